@@ src/object_file_section_parser_top_assert.svh @@
// Assertion macros shared by the checker of the object file section parser.
`ifndef OBJECT_FILE_SECTION_PARSER_TOP_ASSERT_SVH
`define OBJECT_FILE_SECTION_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: name");

// Next-cycle implication, disabled while reset is asserted.
`define OSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: name");

`endif

@@ src/osp_pkg.sv @@
// ----------------------------------------------------------------------------
// Object file section parser package
// Types and constants shared by the parser front end, queue and output stage.
// ----------------------------------------------------------------------------
package osp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned KIND_W = 2;

    localparam logic [WORD_W-1:0] HDR_CODE   = 16'hDECA;
    localparam logic [WORD_W-1:0] HDR_DATA   = 16'hDADA;
    localparam logic [WORD_W-1:0] HDR_SYMBOL = 16'hB7C3;

    // Result kinds as seen on the output port.
    localparam logic [KIND_W-1:0] KIND_CODE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LABEL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ADDR   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_WORDS  = 3'd3,
        PH_LABEL  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        SK_CODE   = 2'd0,
        SK_DATA   = 2'd1,
        SK_SYMBOL = 2'd2
    } section_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] address;
        logic [WORD_W-1:0] value;
        logic              last_char;
    } result_t;

    // Write request from the front end into the queue.
    typedef struct packed {
        logic    push;
        result_t data;
    } q_write_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ src/object_file_section_parser_top.sv @@
// ----------------------------------------------------------------------------
// Object file section parser
// Turns an object file byte stream into word write, label byte and empty label requests.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid/in_stall    byte_in
//  output   out_valid/out_stall  kind, address, value, last_char
//
// One byte is accepted every cycle while in_stall is low; the request that a byte
// causes passes the parser and result queue and is registered at the output.
// in_stall rises only when the result queue of QUEUE_DEPTH entries is full.
// Reset clears the parser state, the queue pointers and the output valid.
module object_file_section_parser_top
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [osp_pkg::BYTE_W-1:0]       byte_in,
    input  logic                             in_valid,
    output logic                             in_stall,
    output logic [osp_pkg::KIND_W-1:0]       kind,
    output logic [osp_pkg::WORD_W-1:0]       address,
    output logic [osp_pkg::WORD_W-1:0]       value,
    output logic                             last_char,
    output logic                             out_valid,
    input  logic                             out_stall
);

    osp_pkg::q_write_t  q_write;
    osp_pkg::q_status_t q_status;
    osp_pkg::result_t   rd_data;
    logic               pop;

    osp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_status (q_status),
        .q_write  (q_write)
    );

    osp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_write  (q_write),
        .pop      (pop),
        .rd_data  (rd_data),
        .q_status (q_status)
    );

    osp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .rd_data   (rd_data),
        .pop       (pop),
        .kind      (kind),
        .address   (address),
        .value     (value),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

@@ src/osp_front.sv @@
// ----------------------------------------------------------------------------
// Object file section parser front end
// Accepts stream bytes, pairs them into words and tracks the section state.
// ----------------------------------------------------------------------------
module osp_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [osp_pkg::BYTE_W-1:0]      byte_in,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  osp_pkg::q_status_t              q_status,
    output osp_pkg::q_write_t               q_write
);

    osp_pkg::phase_t                  phase_reg, phase_next;
    osp_pkg::section_t                section_reg, section_next;
    logic [osp_pkg::BYTE_W-1:0]       high_byte_reg, high_byte_next;
    logic                             high_valid_reg, high_valid_next;
    logic [osp_pkg::WORD_W-1:0]       cur_address_reg, cur_address_next;
    logic [osp_pkg::WORD_W-1:0]       remaining_reg, remaining_next;
    logic [osp_pkg::WORD_W-1:0]       word;
    logic                             accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign word     = {high_byte_reg, byte_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= osp_pkg::PH_HEADER;
            section_reg     <= osp_pkg::SK_CODE;
            high_byte_reg   <= '0;
            high_valid_reg  <= 1'b0;
            cur_address_reg <= '0;
            remaining_reg   <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            section_reg     <= section_next;
            high_byte_reg   <= high_byte_next;
            high_valid_reg  <= high_valid_next;
            cur_address_reg <= cur_address_next;
            remaining_reg   <= remaining_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        section_next     = section_reg;
        high_byte_next   = high_byte_reg;
        high_valid_next  = high_valid_reg;
        cur_address_next = cur_address_reg;
        remaining_next   = remaining_reg;
        q_write.push     = 1'b0;
        q_write.data     = '{kind: osp_pkg::KIND_CODE, address: cur_address_reg,
                             value: word, last_char: 1'b0};

        if (accept)
        begin
            // Label bytes bypass word pairing entirely.
            if (phase_reg == osp_pkg::PH_LABEL)
            begin
                q_write.push           = 1'b1;
                q_write.data.kind      = osp_pkg::KIND_LABEL;
                q_write.data.value     = {{(osp_pkg::WORD_W - osp_pkg::BYTE_W){1'b0}}, byte_in};
                q_write.data.last_char = (remaining_reg == 16'd1);
                remaining_next         = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                begin
                    phase_next = osp_pkg::PH_HEADER;
                end
            end
            else if (!high_valid_reg)
            begin
                high_byte_next  = byte_in;
                high_valid_next = 1'b1;
            end
            else
            begin
                high_valid_next = 1'b0;
                high_byte_next  = '0;
                unique case (phase_reg)
                    osp_pkg::PH_ADDR:
                    begin
                        cur_address_next = word;
                        phase_next       = osp_pkg::PH_COUNT;
                    end
                    osp_pkg::PH_COUNT:
                    begin
                        remaining_next = word;
                        if (word == '0)
                        begin
                            phase_next = osp_pkg::PH_HEADER;
                            if (section_reg == osp_pkg::SK_SYMBOL)
                            begin
                                q_write.push           = 1'b1;
                                q_write.data.kind      = osp_pkg::KIND_EMPTY;
                                q_write.data.value     = '0;
                                q_write.data.last_char = 1'b1;
                            end
                        end
                        else if (section_reg == osp_pkg::SK_SYMBOL)
                        begin
                            phase_next = osp_pkg::PH_LABEL;
                        end
                        else
                        begin
                            phase_next = osp_pkg::PH_WORDS;
                        end
                    end
                    osp_pkg::PH_WORDS:
                    begin
                        q_write.push      = 1'b1;
                        q_write.data.kind = (section_reg == osp_pkg::SK_DATA)
                                            ? osp_pkg::KIND_DATA : osp_pkg::KIND_CODE;
                        cur_address_next  = cur_address_reg + 16'd1;
                        remaining_next    = remaining_reg - 16'd1;
                        if (remaining_reg == 16'd1)
                        begin
                            phase_next = osp_pkg::PH_HEADER;
                        end
                    end
                    default:
                    begin
                        priority if (word == osp_pkg::HDR_CODE)
                        begin
                            section_next = osp_pkg::SK_CODE;
                            phase_next   = osp_pkg::PH_ADDR;
                        end
                        else if (word == osp_pkg::HDR_DATA)
                        begin
                            section_next = osp_pkg::SK_DATA;
                            phase_next   = osp_pkg::PH_ADDR;
                        end
                        else if (word == osp_pkg::HDR_SYMBOL)
                        begin
                            section_next = osp_pkg::SK_SYMBOL;
                            phase_next   = osp_pkg::PH_ADDR;
                        end
                        else
                        begin
                            phase_next = osp_pkg::PH_HEADER;
                        end
                    end
                endcase
            end
        end
    end

endmodule

@@ src/osp_queue.sv @@
// ----------------------------------------------------------------------------
// Object file section parser result queue
// Short FIFO that decouples the parsing front end from the output stage.
// ----------------------------------------------------------------------------
module osp_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  osp_pkg::q_write_t    q_write,
    input  logic                 pop,
    output osp_pkg::result_t     rd_data,
    output osp_pkg::q_status_t   q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    osp_pkg::result_t    mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = q_write.push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign rd_data        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_write.data;
        end
    end

endmodule

@@ src/osp_back.sv @@
// ----------------------------------------------------------------------------
// Object file section parser output stage
// Drains the result queue into a registered output request.
// ----------------------------------------------------------------------------
module osp_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  osp_pkg::q_status_t               q_status,
    input  osp_pkg::result_t                 rd_data,
    output logic                             pop,
    output logic [osp_pkg::KIND_W-1:0]       kind,
    output logic [osp_pkg::WORD_W-1:0]       address,
    output logic [osp_pkg::WORD_W-1:0]       value,
    output logic                             last_char,
    output logic                             out_valid,
    input  logic                             out_stall
);

    logic             valid_reg;
    osp_pkg::result_t data_reg;

    // Load whenever the output register is empty or its request is taken.
    assign pop = !q_status.empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !out_stall)
        begin
            valid_reg <= !q_status.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= rd_data;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = data_reg.kind;
    assign address   = data_reg.address;
    assign value     = data_reg.value;
    assign last_char = data_reg.last_char;

endmodule

@@ src/osp_checker.sv @@
// ----------------------------------------------------------------------------
// Object file section parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "object_file_section_parser_top_assert.svh"

module osp_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic [osp_pkg::BYTE_W-1:0]       byte_in,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [osp_pkg::KIND_W-1:0]       kind,
    input logic [osp_pkg::WORD_W-1:0]       address,
    input logic [osp_pkg::WORD_W-1:0]       value,
    input logic                             last_char,
    input logic                             out_valid,
    input logic                             out_stall
);

    logic        unused_in;
    logic        out_held;
    logic        is_word;
    logic        is_empty;
    logic        is_label;
    logic [34:0] payload;

    assign unused_in = ^{byte_in, in_valid, in_stall};
    assign out_held  = out_valid && out_stall;
    assign is_word   = out_valid && (kind == osp_pkg::KIND_CODE || kind == osp_pkg::KIND_DATA);
    assign is_empty  = out_valid && (kind == osp_pkg::KIND_EMPTY);
    assign is_label  = out_valid && (kind == osp_pkg::KIND_LABEL);
    assign payload   = {kind, address, value, last_char};

    `OSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid)
    `OSP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(payload))
    `OSP_ASSERT_IMPLY(a_word_not_last, clk, rst_n, is_word, !last_char)
    `OSP_ASSERT_IMPLY(a_empty_label, clk, rst_n, is_empty, last_char && value == '0)
    `OSP_ASSERT_IMPLY(a_label_byte, clk, rst_n, is_label, value[15:8] == 8'h00)

endmodule

bind object_file_section_parser_top osp_checker u_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Object file section parser testbench
// Feeds a directed table of object file bytes, then random sections, noise and
// broken sections, with random idling on both channels. Every output request
// is checked field by field against the directed table or a byte-level model of the parser.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned IDLE_PCT     = 37;

    typedef struct packed {
        logic [osp_pkg::BYTE_W-1:0] data;
        logic                       fixed;
        osp_pkg::result_t           req;
    } dir_row_t;

    typedef struct {
        logic [osp_pkg::BYTE_W-1:0] data;
        bit                         fixed;
        bit                         drain;
        osp_pkg::result_t           req;
    } feed_t;

    // Rows with fixed set carry the request that the byte must complete.
    localparam dir_row_t DIRECTED_ROWS [0:30] = '{
        // Unknown header word 0x00FF is skipped.
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        // Code section at 0xFFFF with two words; the second address wraps.
        '{osp_pkg::HDR_CODE[15:8], 1'b0, '0},
        '{osp_pkg::HDR_CODE[7:0],  1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{osp_pkg::KIND_CODE, 16'hFFFF, 16'hFF00, 1'b0}},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{osp_pkg::KIND_CODE, 16'h0000, 16'h0000, 1'b0}},
        // Symbol with an empty label.
        '{osp_pkg::HDR_SYMBOL[15:8], 1'b0, '0},
        '{osp_pkg::HDR_SYMBOL[7:0],  1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{osp_pkg::KIND_EMPTY, 16'h0010, 16'h0000, 1'b1}},
        // Symbol with a one byte label; pairing restarts after it.
        '{osp_pkg::HDR_SYMBOL[15:8], 1'b0, '0},
        '{osp_pkg::HDR_SYMBOL[7:0],  1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h41, 1'b1, '{osp_pkg::KIND_LABEL, 16'h8000, 16'h0041, 1'b1}},
        // Data section with a zero count gives nothing.
        '{osp_pkg::HDR_DATA[15:8], 1'b0, '0},
        '{osp_pkg::HDR_DATA[7:0],  1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}
    };

    logic                       clk       = 1'b0;
    logic                       rst_n;
    logic [osp_pkg::BYTE_W-1:0] byte_in   = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [osp_pkg::KIND_W-1:0] kind;
    logic [osp_pkg::WORD_W-1:0] address;
    logic [osp_pkg::WORD_W-1:0] value;
    logic                       last_char;
    logic                       out_valid;
    logic                       out_stall = 1'b0;

    feed_t            byte_feed[$];
    osp_pkg::result_t predicted_requests[$];
    int               send_idx   = 0;
    int               mismatches = 0;

    // Parser model state, at its reset values.
    osp_pkg::phase_t            ph       = osp_pkg::PH_HEADER;
    logic [osp_pkg::BYTE_W-1:0] hi_byte  = '0;
    logic                       hi_valid = 1'b0;
    osp_pkg::section_t          sect     = osp_pkg::SK_CODE;
    logic [osp_pkg::WORD_W-1:0] cur_addr = '0;
    logic [osp_pkg::WORD_W-1:0] left     = '0;

    object_file_section_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .address   (address),
        .value     (value),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    always #5 clk = ~clk;

    task automatic parse_byte(input logic [osp_pkg::BYTE_W-1:0] b, output bit got,
                              output osp_pkg::result_t req);
        logic [osp_pkg::WORD_W-1:0] w;
        got = 1'b0;
        req = '0;
        if (ph == osp_pkg::PH_LABEL)
        begin
            got = 1'b1;
            req = '{osp_pkg::KIND_LABEL, cur_addr, {8'h00, b}, left == 16'd1};
            left = left - 16'd1;
            if (left == 16'd0)
                ph = osp_pkg::PH_HEADER;
        end
        else if (!hi_valid)
        begin
            hi_byte  = b;
            hi_valid = 1'b1;
        end
        else
        begin
            w        = {hi_byte, b};
            hi_valid = 1'b0;
            hi_byte  = '0;
            unique case (ph)
                osp_pkg::PH_ADDR:
                begin
                    cur_addr = w;
                    ph       = osp_pkg::PH_COUNT;
                end
                osp_pkg::PH_COUNT:
                begin
                    left = w;
                    if (w == 16'd0)
                    begin
                        ph = osp_pkg::PH_HEADER;
                        if (sect == osp_pkg::SK_SYMBOL)
                        begin
                            got = 1'b1;
                            req = '{osp_pkg::KIND_EMPTY, cur_addr, 16'h0000, 1'b1};
                        end
                    end
                    else
                        ph = (sect == osp_pkg::SK_SYMBOL) ? osp_pkg::PH_LABEL
                                                          : osp_pkg::PH_WORDS;
                end
                osp_pkg::PH_WORDS:
                begin
                    got = 1'b1;
                    req = '{(sect == osp_pkg::SK_DATA) ? osp_pkg::KIND_DATA
                                                       : osp_pkg::KIND_CODE,
                            cur_addr, w, 1'b0};
                    cur_addr = cur_addr + 16'd1;
                    left     = left - 16'd1;
                    if (left == 16'd0)
                        ph = osp_pkg::PH_HEADER;
                end
                default:
                begin
                    ph = osp_pkg::PH_ADDR;
                    if (w == osp_pkg::HDR_CODE)
                        sect = osp_pkg::SK_CODE;
                    else if (w == osp_pkg::HDR_DATA)
                        sect = osp_pkg::SK_DATA;
                    else if (w == osp_pkg::HDR_SYMBOL)
                        sect = osp_pkg::SK_SYMBOL;
                    else
                        ph = osp_pkg::PH_HEADER;
                end
            endcase
        end
    endtask

    task automatic add_byte(input logic [osp_pkg::BYTE_W-1:0] b);
        feed_t entry;
        entry.data  = b;
        entry.fixed = 1'b0;
        entry.drain = 1'b0;
        entry.req   = '0;
        byte_feed.push_back(entry);
    endtask

    task automatic add_word(input logic [osp_pkg::WORD_W-1:0] w);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endtask

    // A section announcing count units but carrying only sent of them.
    task automatic add_section(input osp_pkg::section_t sk, input int count, input int sent);
        logic [osp_pkg::WORD_W-1:0] start;
        unique case (sk)
            osp_pkg::SK_CODE:   add_word(osp_pkg::HDR_CODE);
            osp_pkg::SK_DATA:   add_word(osp_pkg::HDR_DATA);
            default:            add_word(osp_pkg::HDR_SYMBOL);
        endcase
        if ($urandom_range(0, 7) == 0)
            start = 16'hFFFF - 16'($urandom_range(0, 3));
        else
            start = 16'($urandom);
        add_word(start);
        add_word(16'(count));
        for (int i = 0; i < sent; i++)
        begin
            if (sk == osp_pkg::SK_SYMBOL)
                add_byte(8'($urandom_range(0, 255)));
            else
                add_word(16'($urandom));
        end
    endtask

    task automatic build_feed();
        feed_t entry;
        int    first_random;
        int    pick;
        int    n;
        foreach (DIRECTED_ROWS[i])
        begin
            entry.data  = DIRECTED_ROWS[i].data;
            entry.fixed = DIRECTED_ROWS[i].fixed;
            entry.drain = 1'b0;
            entry.req   = DIRECTED_ROWS[i].req;
            byte_feed.push_back(entry);
        end
        first_random = byte_feed.size();
        while (byte_feed.size() < first_random + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
                n = $urandom_range(0, 5);
            else
                n = $urandom_range(6, 40);
            if (pick < 80)
                add_section(osp_pkg::section_t'($urandom_range(0, 2)), n, n);
            else if (pick < 88)
            begin
                repeat (2 * $urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 93)
            begin
                // A stray byte shifts the word pairing; a second one restores it.
                add_byte(8'($urandom_range(0, 255)));
                add_section(osp_pkg::section_t'($urandom_range(0, 2)), n, n);
                add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 6);
                add_section(osp_pkg::section_t'($urandom_range(0, 2)), n,
                            $urandom_range(0, n - 1));
            end
        end
        byte_feed[first_random].drain       = 1'b1;
        byte_feed[first_random + 700].drain = 1'b1;
    endtask

    // Output checking and input driving share one process so that the queue of
    // predicted requests is read and written in a fixed order at each edge.
    always @(posedge clk)
    begin : traffic
        osp_pkg::result_t want;
        osp_pkg::result_t req;
        bit               got;
        bit               calm;
        if (rst_n)
        begin
            calm = (send_idx >= 500) && (send_idx < 800);
            if (out_valid && !out_stall)
            begin
                if (predicted_requests.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected request: kind %0d address %h value %h last %b",
                                 kind, address, value, last_char);
                end
                else
                begin
                    want = predicted_requests.pop_front();
                    if (kind !== want.kind || address !== want.address ||
                        value !== want.value || last_char !== want.last_char)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("request mismatch: expected %0d %h %h %b, got %0d %h %h %b",
                                     want.kind, want.address, want.value, want.last_char,
                                     kind, address, value, last_char);
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

            if (in_valid && !in_stall)
            begin
                parse_byte(byte_in, got, req);
                if (byte_feed[send_idx].fixed)
                    predicted_requests.push_back(byte_feed[send_idx].req);
                else if (got)
                    predicted_requests.push_back(req);
                send_idx++;
            end
            // A stalled byte stays on the port unchanged.
            if (!(in_valid && in_stall))
            begin
                if (send_idx < byte_feed.size() &&
                    !(byte_feed[send_idx].drain && predicted_requests.size() != 0) &&
                    !(!calm && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    byte_in  <= byte_feed[send_idx].data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        build_feed();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (send_idx < byte_feed.size() || predicted_requests.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
